// ===== rtl/core/bste_pkg.sv =====
package bste_pkg;

   localparam int KEY_W             = 32;
   localparam int VALUE_W           = 64;
   localparam int STATUS_W          = 3;
   localparam int NODE_W            = 10;
   localparam int COUNT_W           = 11;
   localparam int COUNT_MAX         = 2047;
   localparam int DEFAULT_MAX_NODES = 1024;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic                idle;
      logic                start_walk;
      logic                walk_step;
      logic                read_next;
      logic                write_new;
      logic                write_link;
      logic                load_rsp;
      logic [STATUS_W-1:0] rsp_code;
   } bste_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_fire;
      logic is_search;
      logic empty;
      logic full;
      logic hit;
      logic go_on;
      logic out_free;
   } bste_stat_type;

endpackage

// ===== rtl/core/bste_req_if.sv =====
interface bste_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic signed [bste_pkg::KEY_W-1:0]    key;
   logic signed [bste_pkg::VALUE_W-1:0]  payload;

   modport source (output valid, output req_type, output key, output payload, input ready);
   modport sink   (input valid, input req_type, input key, input payload, output ready);
endinterface

// ===== rtl/core/bste_rsp_if.sv =====
interface bste_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bste_pkg::STATUS_W-1:0]        status;
   logic [bste_pkg::NODE_W-1:0]          node_index;
   logic [bste_pkg::NODE_W-1:0]          parent_index;
   logic signed [bste_pkg::VALUE_W-1:0]  found_value;
   logic [bste_pkg::COUNT_W-1:0]         compare_count;

   modport source (output valid, output status, output node_index, output parent_index,
                   output found_value, output compare_count, input ready);
   modport sink   (input valid, input status, input node_index, input parent_index,
                   input found_value, input compare_count, output ready);
endinterface

// ===== rtl/core/binary_search_tree_engine.sv =====
// Binary search tree engine: insert and search on an unbalanced tree whose
// nodes live in a single-port-write, registered-read node memory.
// req_chan carries one request per transfer (req_type, key, payload);
// rsp_chan returns exactly one result per request, in request order.
// The block takes one request at a time: ready is high only while idle.
// States after DISPATCH up to result load; FINISH waits for a free result buffer:
//   store full, or empty tree search: FINISH
//   empty tree insert: WR_NEW, FINISH
//   search or duplicate insert: WALK over the nodes compared, FINISH
//   insert below a node: WALK, WR_NEW (new node), WR_LINK (parent link), FINISH
// The walk compares one node per cycle; the memory read for the next level is
// issued from the current compare, so the node memory read port sets the rate.
// A request can be accepted again in the cycle after its result is loaded.
// The result sits in an output register; if the receiver stalls, a finished
// request waits there and the next request still runs up to its own result.
// Reset empties the tree (node count to zero) and drops any pending result;
// node memory contents need no clearing.
module binary_search_tree_engine #(
   parameter int MAX_NODES = bste_pkg::DEFAULT_MAX_NODES
) (
   input logic        clock,
   input logic        reset,
   bste_req_if.sink   req_chan,
   bste_rsp_if.source rsp_chan
);

   bste_pkg::bste_cmd_type  cmd;
   bste_pkg::bste_stat_type stat;

   bste_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   bste_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

// ===== rtl/core/bste_ram.sv =====
module bste_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bste_datapath.sv =====
module bste_datapath #(
   parameter int MAX_NODES = bste_pkg::DEFAULT_MAX_NODES
) (
   input  logic                   clock,
   input  logic                   reset,
   bste_req_if.sink               req_chan,
   bste_rsp_if.source             rsp_chan,
   input  bste_pkg::bste_cmd_type cmd,
   output bste_pkg::bste_stat_type stat
);

   localparam int IDX_W   = $clog2(MAX_NODES);
   localparam int LINK_W  = $clog2(MAX_NODES + 1);
   localparam int KEY_W   = bste_pkg::KEY_W;
   localparam int VALUE_W = bste_pkg::VALUE_W;
   localparam int ENTRY_W = KEY_W + VALUE_W + 2 * LINK_W;
   localparam int RIGHT_LO = 0;
   localparam int LEFT_LO  = LINK_W;
   localparam int VALUE_LO = 2 * LINK_W;
   localparam int KEY_LO   = 2 * LINK_W + VALUE_W;
   localparam logic [LINK_W-1:0] LINK_NULL = '1;

   // request
   logic                      type_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0]        payload_ff;

   // walk
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [IDX_W-1:0]  node_ff, node_in;
   logic [LINK_W-1:0] count_ff, count_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] used_ff, used_in;
   logic              go_right_ff, go_right_in;

   // result buffer
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bste_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bste_pkg::NODE_W-1:0]   rsp_node_ff, rsp_parent_ff;
   logic [VALUE_W-1:0]            rsp_value_ff;
   logic [bste_pkg::COUNT_W-1:0]  rsp_count_ff;

   // memory
   logic               ram_we, ram_re;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic signed [KEY_W-1:0] node_key;
   logic [VALUE_W-1:0]      node_value;
   logic [LINK_W-1:0]       left_link, right_link, next_link;
   logic                    hit, go_right;
   logic [LINK_W-1:0]       fresh_link;
   logic [31:0]             node_wide, last_wide, count_wide;
   logic                    has_node;

   assign node_key   = ram_rdata[KEY_LO +: KEY_W];
   assign node_value = ram_rdata[VALUE_LO +: VALUE_W];
   assign left_link  = ram_rdata[LEFT_LO +: LINK_W];
   assign right_link = ram_rdata[RIGHT_LO +: LINK_W];

   assign hit       = (node_key == key_ff);
   assign go_right  = (key_ff > node_key);
   assign next_link = go_right ? right_link : left_link;

   assign req_chan.ready = cmd.idle;

   assign stat.req_fire  = req_chan.valid && req_chan.ready;
   assign stat.is_search = (type_ff == bste_pkg::REQ_SEARCH);
   assign stat.empty     = (used_ff == '0);
   assign stat.full      = (used_ff == LINK_W'(MAX_NODES));
   assign stat.hit       = hit;
   assign stat.go_on     = (next_link < used_ff) && ((steps_ff + LINK_W'(1)) < used_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign fresh_link = LINK_W'(node_ff);

   always_comb begin
      ram_re    = cmd.start_walk || cmd.read_next;
      ram_raddr = cmd.start_walk ? '0 : next_link[IDX_W-1:0];
      ram_we    = cmd.write_new || cmd.write_link;
      ram_waddr = cmd.write_new ? used_ff[IDX_W-1:0] : last_ff;
      ram_wdata = ram_rdata;
      if (cmd.write_new) begin
         ram_wdata = {key_ff, payload_ff, LINK_NULL, LINK_NULL};
      end else if (go_right_ff) begin
         ram_wdata[RIGHT_LO +: LINK_W] = fresh_link;
      end else begin
         ram_wdata[LEFT_LO +: LINK_W] = fresh_link;
      end
   end

   bste_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      cur_in      = cur_ff;
      last_in     = last_ff;
      node_in     = node_ff;
      count_in    = count_ff;
      steps_in    = steps_ff;
      used_in     = used_ff;
      go_right_in = go_right_ff;
      if (stat.req_fire) begin
         last_in  = '0;
         node_in  = '0;
         count_in = '0;
         steps_in = '0;
      end
      if (cmd.start_walk) begin
         cur_in = '0;
      end
      if (cmd.walk_step) begin
         last_in     = cur_ff;
         node_in     = cur_ff;
         count_in    = count_ff + LINK_W'(1);
         steps_in    = steps_ff + LINK_W'(1);
         go_right_in = go_right;
      end
      if (cmd.read_next) begin
         cur_in = next_link[IDX_W-1:0];
      end
      if (cmd.write_new) begin
         node_in = used_ff[IDX_W-1:0];
         used_in = used_ff + LINK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      node_ff     <= node_in;
      count_ff    <= count_in;
      steps_ff    <= steps_in;
      go_right_ff <= go_right_in;
      if (stat.req_fire) begin
         type_ff    <= req_chan.req_type;
         key_ff     <= req_chan.key;
         payload_ff <= req_chan.payload;
      end
   end

   // result formatting
   assign node_wide  = 32'(node_ff);
   assign last_wide  = 32'(last_ff);
   assign count_wide = 32'(count_ff);
   assign has_node   = (cmd.rsp_code == bste_pkg::ST_FOUND) ||
                       (cmd.rsp_code == bste_pkg::ST_DUPLICATE) ||
                       (cmd.rsp_code == bste_pkg::ST_INSERTED);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_node_ff   <= has_node ? node_wide[bste_pkg::NODE_W-1:0] : '0;
         rsp_parent_ff <= last_wide[bste_pkg::NODE_W-1:0];
         rsp_value_ff  <= (cmd.rsp_code == bste_pkg::ST_FOUND) ? node_value : '0;
         rsp_count_ff  <= (count_wide > 32'(bste_pkg::COUNT_MAX)) ?
                          bste_pkg::COUNT_W'(bste_pkg::COUNT_MAX) :
                          count_wide[bste_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.node_index    = rsp_node_ff;
   assign rsp_chan.parent_index  = rsp_parent_ff;
   assign rsp_chan.found_value   = rsp_value_ff;
   assign rsp_chan.compare_count = rsp_count_ff;

endmodule

// ===== rtl/core/bste_ctrl.sv =====
module bste_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  bste_pkg::bste_stat_type stat,
   output bste_pkg::bste_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_WALK     = 3'd2;
   localparam logic [2:0] S_WR_NEW   = 3'd3;
   localparam logic [2:0] S_WR_LINK  = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [bste_pkg::STATUS_W-1:0] code_ff, code_in;
   logic                          link_ff, link_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      link_in  = link_ff;
      cmd      = '0;
      cmd.rsp_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (stat.req_fire) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.is_search && stat.full) begin
               code_in  = bste_pkg::ST_FULL;
               state_in = S_FINISH;
            end else if (stat.empty) begin
               if (stat.is_search) begin
                  code_in  = bste_pkg::ST_NOT_FOUND;
                  state_in = S_FINISH;
               end else begin
                  // first node becomes the root, no parent link
                  code_in  = bste_pkg::ST_INSERTED;
                  link_in  = 1'b0;
                  state_in = S_WR_NEW;
               end
            end else begin
               cmd.start_walk = 1'b1;
               state_in       = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.hit) begin
               code_in  = stat.is_search ? bste_pkg::ST_FOUND : bste_pkg::ST_DUPLICATE;
               state_in = S_FINISH;
            end else if (stat.go_on) begin
               cmd.read_next = 1'b1;
            end else if (stat.is_search) begin
               code_in  = bste_pkg::ST_NOT_FOUND;
               state_in = S_FINISH;
            end else begin
               code_in  = bste_pkg::ST_INSERTED;
               link_in  = 1'b1;
               state_in = S_WR_NEW;
            end
         end
         S_WR_NEW: begin
            cmd.write_new = 1'b1;
            state_in      = link_ff ? S_WR_LINK : S_FINISH;
         end
         S_WR_LINK: begin
            cmd.write_link = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
      link_ff <= link_in;
   end

endmodule

// ===== rtl/core/bste_checker.sv =====
module bste_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bste_pkg::STATUS_W-1:0]       rsp_status,
   input logic [bste_pkg::NODE_W-1:0]         rsp_node_index,
   input logic [bste_pkg::NODE_W-1:0]         rsp_parent_index,
   input logic signed [bste_pkg::VALUE_W-1:0] rsp_found_value,
   input logic [bste_pkg::COUNT_W-1:0]        rsp_compare_count
);

   // a result stays offered until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // one request in flight: ready falls after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // only a hit carries a stored value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bste_pkg::ST_FOUND |-> rsp_found_value == '0)
      else $error("value reported without a hit");

   // a hit names the same node as index and parent, after at least one compare
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bste_pkg::ST_FOUND || rsp_status == bste_pkg::ST_DUPLICATE)
      |-> rsp_node_index == rsp_parent_index && rsp_compare_count != '0)
      else $error("hit result inconsistent");

   // store full does no walk
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bste_pkg::ST_FULL
      |-> rsp_node_index == '0 && rsp_parent_index == '0 && rsp_compare_count == '0)
      else $error("store full result carries walk data");

endmodule

bind binary_search_tree_engine bste_checker u_bste_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_node_index    (rsp_chan.node_index),
   .rsp_parent_index  (rsp_chan.parent_index),
   .rsp_found_value   (rsp_chan.found_value),
   .rsp_compare_count (rsp_chan.compare_count)
);

// ===== tb/tb_binary_search_tree_engine.sv =====
`timescale 1ns / 100ps

module tb_binary_search_tree_engine;

   localparam int NODE_LIMIT   = bste_pkg::DEFAULT_MAX_NODES;
   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT   = 20000;
   localparam int TAIL_CYCLES  = 64;

   typedef struct packed {
      logic                                kind;
      logic signed [bste_pkg::KEY_W-1:0]   key;
      logic signed [bste_pkg::VALUE_W-1:0] payload;
      logic                                drain;
   } tree_request_type;

   typedef struct packed {
      logic [bste_pkg::STATUS_W-1:0] status;
      logic [bste_pkg::NODE_W-1:0]   node_index;
      logic [bste_pkg::NODE_W-1:0]   parent_index;
      logic [bste_pkg::VALUE_W-1:0]  found_value;
      logic [bste_pkg::COUNT_W-1:0]  compare_count;
   } tree_result_type;

   logic clock;
   logic reset;

   bste_req_if req_bus();
   bste_rsp_if rsp_bus();

   binary_search_tree_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow copy of the node memory
   int     tree_key [NODE_LIMIT];
   longint tree_value [NODE_LIMIT];
   int     left_child [NODE_LIMIT];
   int     right_child [NODE_LIMIT];
   int     tree_size = 0;

   tree_request_type request_queue[$];
   tree_result_type  expected_results[$];

   // stimulus-side bookkeeping of keys queued for insertion into the tree
   bit key_used[int];
   int key_list[$];
   int distinct_keys = 0;

   int          errors = 0;
   int          accepted_total = 0;
   int          result_total = 0;
   int          insert_total = 0;
   int          search_total = 0;
   int          idle_cycles = 0;
   int          deepest_walk = 0;
   int          status_seen [8];
   int          send_gap = 0;
   int          rsp_hold = 0;
   bit          req_fired = 1'b0;
   bit          calm = 1'b0;
   logic [31:0] tick = '0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic tree_result_type walk_tree(input logic kind, input int k,
                                                 input longint v);
      tree_result_type res;
      int              cur;
      int              last;
      int              steps;
      int              nxt;
      bit              right_turn;
      bit              hit;
      res = '0;
      cur = 0;
      last = 0;
      steps = 0;
      right_turn = 1'b0;
      hit = 1'b0;
      if (kind == bste_pkg::REQ_INSERT && tree_size >= NODE_LIMIT) begin
         res.status = bste_pkg::ST_FULL;
         return res;
      end
      if (tree_size == 0) begin
         if (kind == bste_pkg::REQ_SEARCH) begin
            res.status = bste_pkg::ST_NOT_FOUND;
         end else begin
            tree_key[0] = k;
            tree_value[0] = v;
            left_child[0] = -1;
            right_child[0] = -1;
            tree_size = 1;
            res.status = bste_pkg::ST_INSERTED;
         end
         return res;
      end
      while (steps < tree_size) begin
         steps++;
         last = cur;
         if (k == tree_key[cur]) begin
            hit = 1'b1;
            break;
         end
         right_turn = k > tree_key[cur];
         nxt = right_turn ? right_child[cur] : left_child[cur];
         if (nxt < 0 || nxt >= tree_size) break;
         cur = nxt;
      end
      res.compare_count = (steps > bste_pkg::COUNT_MAX) ? bste_pkg::COUNT_MAX : steps;
      res.parent_index = last;
      if (kind == bste_pkg::REQ_SEARCH) begin
         if (hit) begin
            res.status = bste_pkg::ST_FOUND;
            res.node_index = last;
            res.found_value = tree_value[last];
         end else begin
            res.status = bste_pkg::ST_NOT_FOUND;
         end
      end else if (hit) begin
         res.status = bste_pkg::ST_DUPLICATE;
         res.node_index = last;
      end else begin
         tree_key[tree_size] = k;
         tree_value[tree_size] = v;
         left_child[tree_size] = -1;
         right_child[tree_size] = -1;
         if (right_turn) right_child[last] = tree_size;
         else left_child[last] = tree_size;
         res.status = bste_pkg::ST_INSERTED;
         res.node_index = tree_size;
         tree_size++;
      end
      return res;
   endfunction

   task automatic add_request(input logic kind, input int k, input longint v, input bit drain);
      tree_request_type item;
      item.kind = kind;
      item.key = k;
      item.payload = v;
      item.drain = drain;
      request_queue.push_back(item);
      if (kind == bste_pkg::REQ_INSERT && distinct_keys < NODE_LIMIT && !key_used.exists(k))
      begin
         key_used[k] = 1'b1;
         key_list.push_back(k);
         distinct_keys++;
      end
   endtask

   function automatic longint random_payload();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 64'sh8000_0000_0000_0000;
      if (pick == 1) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return {$urandom, $urandom};
   endfunction

   function automatic int known_key();
      return key_list[$urandom_range(0, key_list.size() - 1)];
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 80) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      tree_request_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap--;
         end else if (request_queue.size() == 0 ||
                      (request_queue[0].drain && expected_results.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else begin
            item = request_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.req_type <= item.kind;
            req_bus.key <= item.key;
            req_bus.payload <= item.payload;
            send_gap = calm ? 0 : pick_gap();
         end
      end
   end

   // result receiver backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   // monitor: check results, predict on each accepted request
   always @(posedge clock) begin
      tree_result_type want;
      tree_result_type got;
      bit              rsp_fire;
      req_fired = 1'b0;
      if (!reset) begin
         tick++;
         calm = (tick[10:9] == 2'b11);
         rsp_fire = rsp_bus.valid && rsp_bus.ready;
         if (rsp_fire) begin
            got.status = rsp_bus.status;
            got.node_index = rsp_bus.node_index;
            got.parent_index = rsp_bus.parent_index;
            got.found_value = rsp_bus.found_value;
            got.compare_count = rsp_bus.compare_count;
            result_total++;
            status_seen[got.status]++;
            if (got.compare_count > deepest_walk) deepest_walk = got.compare_count;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected, expected none, actual %0h",
                        $time, got);
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("node_index", want.node_index, got.node_index);
               check_field("parent_index", want.parent_index, got.parent_index);
               check_field("found_value", want.found_value, got.found_value);
               check_field("compare_count", want.compare_count, got.compare_count);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_fired = 1'b1;
            accepted_total++;
            if (req_bus.req_type == bste_pkg::REQ_INSERT) insert_total++;
            else search_total++;
            expected_results.push_back(walk_tree(req_bus.req_type, req_bus.key,
                                                 req_bus.payload));
         end
         if (req_fired || rsp_fire) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      int     planned;
      int     n;
      int     pick;
      int     k;
      int     run_key;
      int     run_left;
      int     after_full;
      bit     drain;
      longint v;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = bste_pkg::REQ_INSERT;
      req_bus.key = '0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      foreach (status_seen[s]) status_seen[s] = 0;

      // empty tree, root, duplicates, key extremes, short ascending chain
      add_request(bste_pkg::REQ_SEARCH, 0, 0, 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 32'sh8000_0000, -1, 1'b0);
      add_request(bste_pkg::REQ_INSERT, 0, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
      add_request(bste_pkg::REQ_INSERT, 0, 5, 1'b0);
      add_request(bste_pkg::REQ_INSERT, 32'sh8000_0000, 64'sh8000_0000_0000_0000, 1'b0);
      add_request(bste_pkg::REQ_INSERT, 32'sh7FFF_FFFF, -1, 1'b0);
      add_request(bste_pkg::REQ_INSERT, -1, 0, 1'b0);
      add_request(bste_pkg::REQ_INSERT, 1, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 32'sh7FFF_FFFF, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 32'sh8000_0000, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 0, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, -1, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 1, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 2, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, -2, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_INSERT, 32'sh7FFF_FFFF, random_payload(), 1'b0);
      for (int j = 0; j < 8; j++) begin
         add_request(bste_pkg::REQ_INSERT, 1000 + j, random_payload(), 1'b0);
      end
      add_request(bste_pkg::REQ_SEARCH, 1007, random_payload(), 1'b0);
      add_request(bste_pkg::REQ_SEARCH, 1008, random_payload(), 1'b0);

      // random traffic until the tree is full and a tail of requests against the full store
      n = 0;
      run_key = 0;
      run_left = 0;
      after_full = 0;
      while (n < RANDOM_ITEMS || distinct_keys < NODE_LIMIT || after_full < 60) begin
         drain = (n == 0) || ($urandom_range(0, 299) == 0);
         pick = $urandom_range(0, 99);
         v = random_payload();
         if (distinct_keys >= NODE_LIMIT) after_full++;
         if (run_left > 0) begin
            add_request(bste_pkg::REQ_INSERT, run_key, v, drain);
            run_key += $urandom_range(1, 3);
            run_left--;
         end else if (pick < 85) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               k = $urandom;
            end else if (pick < 9) begin
               k = $urandom_range(0, 400) - 200;
            end else begin
               // sorted run builds a deeper branch
               k = $urandom;
               run_key = k + 1;
               run_left = $urandom_range(4, 12);
            end
            add_request(bste_pkg::REQ_INSERT, k, v, drain);
         end else if (pick < 88) begin
            add_request(bste_pkg::REQ_INSERT, known_key(), v, drain);
         end else if (pick < 96) begin
            add_request(bste_pkg::REQ_SEARCH, known_key(), v, drain);
         end else begin
            k = ($urandom_range(0, 1) == 0) ? int'($urandom) : known_key() + 1;
            add_request(bste_pkg::REQ_SEARCH, k, v, drain);
         end
         n++;
      end
      planned = request_queue.size();

      repeat (6) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      while ((accepted_total < planned || expected_results.size() != 0) &&
             idle_cycles < IDLE_LIMIT)
         @(posedge clock);

      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d of %0d requests taken",
                  $time, idle_cycles, accepted_total, planned);
         $display("FAILURE");
      end else begin
         repeat (TAIL_CYCLES) @(posedge clock);
         $display("covered %0d requests (%0d inserts, %0d searches), tree grew to %0d nodes",
                  accepted_total, insert_total, search_total, tree_size);
         $display("results: found %0d, not found %0d, inserted %0d, dup %0d, full %0d, deepest %0d",
                  status_seen[bste_pkg::ST_FOUND], status_seen[bste_pkg::ST_NOT_FOUND],
                  status_seen[bste_pkg::ST_INSERTED], status_seen[bste_pkg::ST_DUPLICATE],
                  status_seen[bste_pkg::ST_FULL], deepest_walk);
         if (errors == 0) begin
            $display("SUCCESS");
         end else begin
            $display("FAILURE");
         end
      end
      $finish;
   end

endmodule
